FILE: sv/voxel_neighbour_label_gather_defines.svh
// Assertion macros shared by the checker of the voxel neighbour label gather.
// Needs nothing else; included by the files that carry assertions.
`ifndef VOXEL_NEIGHBOUR_LABEL_GATHER_DEFINES_SVH
`define VOXEL_NEIGHBOUR_LABEL_GATHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VNLG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vnlg assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VNLG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vnlg assertion failed");

`endif

FILE: sv/vnlg_pkg.sv
// Shared types, constants and the neighbour offset table of the voxel label gather.
// No dependencies; imported by every module of the block.
package vnlg_pkg;

    localparam int LABEL_W = 21;
    localparam int IDX_W   = 21;
    localparam int DIM_W   = 8;
    localparam int CONN_W  = 5;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int NID_W   = 26;
    localparam int TABLE_LEN = 26;

    localparam logic [DIM_W-1:0]  DIM_RESET  = 8'd128;
    localparam logic [CONN_W-1:0] CONN_RESET = 5'd26;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_X = 2'd0,
        CFG_DIM_Y = 2'd1,
        CFG_DIM_Z = 2'd2,
        CFG_CONN  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_WALK,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic signed [1:0] x;
        logic signed [1:0] y;
        logic signed [1:0] z;
    } t_off;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] dividend;
        logic [DIM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] quot;
        logic [DIM_W-1:0] rem;
    } t_div_rsp;

    localparam logic signed [1:0] OFF_X [TABLE_LEN] = '{
        2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0,
        2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1,
        2'sd0, 2'sd0, 2'sd0, 2'sd0,
        2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1};
    localparam logic signed [1:0] OFF_Y [TABLE_LEN] = '{
        2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0,
        2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0,
        2'sd1, -2'sd1, 2'sd1, -2'sd1,
        2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1};
    localparam logic signed [1:0] OFF_Z [TABLE_LEN] = '{
        2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1,
        2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, 2'sd1, -2'sd1, -2'sd1,
        2'sd1, 2'sd1, -2'sd1, -2'sd1,
        2'sd1, 2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1, -2'sd1, -2'sd1};

    // Entries past the end of the table read as a zero offset.
    function automatic t_off offset_of(logic [CONN_W-1:0] k);
        t_off o;
        o = '0;
        if (32'(k) < TABLE_LEN) begin
            o.x = OFF_X[k];
            o.y = OFF_Y[k];
            o.z = OFF_Z[k];
        end
        return o;
    endfunction

    // A zero extent acts as one, anything above the maximum acts as the maximum.
    function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] d, int unsigned max_dim);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (32'(d) > max_dim) begin
            r = DIM_W'(max_dim);
        end
        return r;
    endfunction

endpackage

FILE: sv/vnlg_divider.sv
// Shared restoring divider: splits a voxel index by one volume extent, one quotient
// bit per cycle. Depends on vnlg_pkg.
module vnlg_divider
    import vnlg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(IDX_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(IDX_W - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_quo, n_quo;
    logic [DIM_W-1:0] r_rem, n_rem;
    logic [DIM_W-1:0] r_div, n_div;

    logic [DIM_W:0] w_part;
    logic [DIM_W:0] w_diff;
    logic           w_ge;

    assign w_part = {r_rem, r_quo[IDX_W-1]};
    assign w_ge   = w_part >= {1'b0, r_div};
    assign w_diff = w_part - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            // The partial remainder stays below twice the divisor, so the
            // difference always fits the remainder width.
            n_rem = w_ge ? w_diff[DIM_W-1:0] : w_part[DIM_W-1:0];
            n_quo = {r_quo[IDX_W-2:0], w_ge};
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

FILE: sv/vnlg_label_mem.sv
// Label store: one write port and one read port with registered read data.
// Depends on vnlg_pkg for the label width.
module vnlg_label_mem
    import vnlg_pkg::*;
#(
    parameter int DEPTH = 2097152,
    parameter int AW    = 21
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [LABEL_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output logic [LABEL_W-1:0] o_rdata
);

    logic [LABEL_W-1:0] r_mem [DEPTH];
    logic [LABEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/voxel_neighbour_label_gather.sv
// Voxel neighbour label gather, top level.
// Input channel (i_valid / o_stall) carries writes and queries; output channel
// (o_valid / i_stall) carries result transfers; a separate valid/ready port sets
// the extents and the connectivity (o_cfg_ready is always high).
// After reset the label store is cleared one word per cycle, all VOLUME_WORDS words
// in all, with o_stall high; configuration writes are taken during that pass.
// A write transfer is stored in the cycle it is accepted and gives no result;
// the block is ready again at once.
// A query splits its index with the shared shift-subtract divider, one quotient
// bit a cycle: by the x extent, then the y extent, for x, y and z. It then walks
// the offset table, one entry and at most one label store read a cycle unless the
// walk is paused, and ends with the final result; one query at a time.
// Results leave through an output register. While the receiver stalls that
// register holds and the walk pauses once a second found label needs room.
// The last result of every query carries o_last; an empty answer is a single
// transfer with o_found low.
// Depends on vnlg_pkg, vnlg_divider and vnlg_label_mem.
module voxel_neighbour_label_gather
    import vnlg_pkg::*;
#(
    parameter int MAX_DIM      = 128,
    parameter int VOLUME_WORDS = 2097152,
    parameter int NUM_OFFSETS  = 26
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_action,
    input  logic [IDX_W-1:0]     i_voxel_index,
    input  logic [LABEL_W-1:0]   i_mask_label,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [LABEL_W-1:0]   o_neighbour_label,
    output logic                 o_found,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = (VOLUME_WORDS > 1) ? $clog2(VOLUME_WORDS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(VOLUME_WORDS - 1);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [DIM_W-1:0]   r_dim_x, r_dim_y, r_dim_z;
    logic [CONN_W-1:0]  r_conn;
    logic [2*DIM_W-1:0] r_dxy;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [DIM_W-1:0]   r_x, n_x, r_y, n_y, r_z, n_z;
    logic [CONN_W-1:0]  r_k, n_k;
    logic               r_dv, n_dv;
    logic [LABEL_W-1:0] r_pend, n_pend;
    logic               r_pend_v, n_pend_v;
    logic               r_ovalid, n_ovalid;
    logic [LABEL_W-1:0] r_olabel, n_olabel;
    logic               r_ofound, n_ofound;
    logic               r_olast, n_olast;

    logic [DIM_W-1:0]   w_dx, w_dy, w_dz;
    logic [CONN_W-1:0]  w_conn;
    t_off               w_off;
    logic               w_inb;
    logic [NID_W-1:0]   w_tx, w_ty, w_tz, w_nid;
    logic [31:0]        w_nid32, w_widx32;
    logic               w_cand;
    logic               w_out_free;
    logic               w_hit;

    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;
    logic               w_we, w_re;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [LABEL_W-1:0] w_wdata, w_rdata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x <= DIM_RESET;
            r_dim_y <= DIM_RESET;
            r_dim_z <= DIM_RESET;
            r_conn  <= CONN_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DIM_X: r_dim_x <= i_cfg_data;
                CFG_DIM_Y: r_dim_y <= i_cfg_data;
                CFG_DIM_Z: r_dim_z <= i_cfg_data;
                CFG_CONN:  r_conn  <= i_cfg_data[CONN_W-1:0];
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    assign w_dx   = eff_dim(r_dim_x, MAX_DIM);
    assign w_dy   = eff_dim(r_dim_y, MAX_DIM);
    assign w_dz   = eff_dim(r_dim_z, MAX_DIM);
    assign w_conn = (32'(r_conn) > NUM_OFFSETS) ? CONN_W'(NUM_OFFSETS) : r_conn;

    // Plane size; settles long before a walk needs it.
    always_ff @(posedge i_clk) begin
        r_dxy <= (2*DIM_W)'(w_dx) * (2*DIM_W)'(w_dy);
    end

    // Bounds test and linear index of the neighbour at table entry r_k.
    assign w_off = offset_of(r_k);

    always_comb begin
        w_inb = 1'b1;
        if (w_off.x == 2'sd1 && (9'(r_x) + 9'd1) >= 9'(w_dx)) w_inb = 1'b0;
        if (w_off.x == -2'sd1 && r_x == '0) w_inb = 1'b0;
        if (w_off.y == 2'sd1 && (9'(r_y) + 9'd1) >= 9'(w_dy)) w_inb = 1'b0;
        if (w_off.y == -2'sd1 && r_y == '0) w_inb = 1'b0;
        if (w_off.z == 2'sd1 && (9'(r_z) + 9'd1) >= 9'(w_dz)) w_inb = 1'b0;
        if (w_off.z == -2'sd1 && r_z == '0) w_inb = 1'b0;
    end

    // Offsets are added in two's complement; the sum is only used in bounds.
    assign w_tx = (w_off.x == 2'sd1) ? NID_W'(1) :
                  (w_off.x == -2'sd1) ? '1 : '0;
    assign w_ty = (w_off.y == 2'sd1) ? NID_W'(w_dx) :
                  (w_off.y == -2'sd1) ? (NID_W'(0) - NID_W'(w_dx)) : '0;
    assign w_tz = (w_off.z == 2'sd1) ? NID_W'(r_dxy) :
                  (w_off.z == -2'sd1) ? (NID_W'(0) - NID_W'(r_dxy)) : '0;
    assign w_nid   = NID_W'(r_idx) + w_tx + w_ty + w_tz;
    assign w_nid32 = 32'(w_nid);
    assign w_cand  = w_inb && (w_nid32 < 32'(VOLUME_WORDS));

    assign w_widx32   = 32'(i_voxel_index);
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_hit      = r_dv && (w_rdata != '0);

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_idx     = r_idx;
        n_x       = r_x;
        n_y       = r_y;
        n_z       = r_z;
        n_k       = r_k;
        n_dv      = r_dv;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        n_ovalid  = r_ovalid && i_stall;
        n_olabel  = r_olabel;
        n_ofound  = r_ofound;
        n_olast   = r_olast;
        w_div_req = '0;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = '0;
        w_re      = 1'b0;
        w_raddr   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                if (r_clr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_action == ACT_WRITE) begin
                        w_we    = w_widx32 < 32'(VOLUME_WORDS);
                        w_waddr = w_widx32[AW-1:0];
                        w_wdata = i_mask_label;
                    end else begin
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = i_voxel_index;
                        w_div_req.divisor  = w_dx;
                        n_idx   = i_voxel_index;
                        n_state = ST_DIV_X;
                    end
                end
            end
            ST_DIV_X: begin
                if (w_div_rsp.done) begin
                    n_x = w_div_rsp.rem;
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = w_div_rsp.quot;
                    w_div_req.divisor  = w_dy;
                    n_state = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (w_div_rsp.done) begin
                    n_y      = w_div_rsp.rem;
                    n_z      = w_div_rsp.quot[DIM_W-1:0];
                    n_k      = '0;
                    n_dv     = 1'b0;
                    n_pend_v = 1'b0;
                    // A z beyond the last plane means the index lies outside.
                    n_state  = (w_div_rsp.quot < IDX_W'(w_dz)) ? ST_WALK : ST_FIN;
                end
            end
            ST_WALK: begin
                // A second found label pushes the held one out; if the output
                // register has no room the whole walk waits.
                if (!(w_hit && r_pend_v && !w_out_free)) begin
                    if (w_hit) begin
                        if (r_pend_v) begin
                            n_ovalid = 1'b1;
                            n_olabel = r_pend;
                            n_ofound = 1'b1;
                            n_olast  = 1'b0;
                        end
                        n_pend   = w_rdata;
                        n_pend_v = 1'b1;
                    end
                    if (r_k < w_conn) begin
                        w_re    = w_cand;
                        w_raddr = w_nid32[AW-1:0];
                        n_dv    = w_cand;
                        n_k     = r_k + CONN_W'(1);
                    end else begin
                        n_dv = 1'b0;
                        if (!r_dv) begin
                            n_state = ST_FIN;
                        end
                    end
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_olabel = r_pend_v ? r_pend : '0;
                    n_ofound = r_pend_v;
                    n_olast  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_k      <= '0;
            r_dv     <= 1'b0;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_k      <= n_k;
            r_dv     <= n_dv;
            r_pend_v <= n_pend_v;
            r_ovalid <= n_ovalid;
        end
        r_idx    <= n_idx;
        r_x      <= n_x;
        r_y      <= n_y;
        r_z      <= n_z;
        r_pend   <= n_pend;
        r_olabel <= n_olabel;
        r_ofound <= n_ofound;
        r_olast  <= n_olast;
    end

    vnlg_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    vnlg_label_mem #(
        .DEPTH (VOLUME_WORDS),
        .AW    (AW)
    ) u_label_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_stall           = (r_state != ST_IDLE);
    assign o_valid           = r_ovalid;
    assign o_neighbour_label = r_olabel;
    assign o_found           = r_ofound;
    assign o_last            = r_olast;

endmodule

FILE: sv/vnlg_checker.sv
// Port-level checker for the voxel neighbour label gather, bound to the top level.
// Depends on vnlg_pkg and the assertion macros in the defines header.
`include "voxel_neighbour_label_gather_defines.svh"

module vnlg_checker
    import vnlg_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               i_action,
    input logic               o_valid,
    input logic               i_stall,
    input logic [LABEL_W-1:0] o_neighbour_label,
    input logic               o_found,
    input logic               o_last
);

    // A result waiting on a stalled receiver keeps its contents.
    `VNLG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_neighbour_label) && $stable(o_found) && $stable(o_last))

    // An empty answer is always the final result and carries no label.
    `VNLG_ASSERT_NOW(a_empty_final, i_clk, i_rst_n, o_valid && !o_found, o_last && (o_neighbour_label == '0))

    // A query occupies the block from the cycle after its transfer.
    `VNLG_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, i_valid && !o_stall && (i_action == ACT_QUERY), o_stall)

    // While a query still has results to come, no new item is taken.
    `VNLG_ASSERT_NOW(a_busy_until_last, i_clk, i_rst_n, o_valid && !o_last, o_stall)

endmodule

bind voxel_neighbour_label_gather vnlg_checker u_vnlg_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .i_action          (i_action),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_neighbour_label (o_neighbour_label),
    .o_found           (o_found),
    .o_last            (o_last)
);
